// File: rtl/ilst_pkg.sv
// Shared types and codes for the indexed list store.
// Used by ilst_cell, indexed_list_store_unit and the testbench; depends on nothing else.
`timescale 1ns / 1ps

package ilst_pkg;

   // Field widths of the request and response items.
   localparam int ValueW  = 32;
   localparam int PosW    = 4;
   localparam int KindW   = 2;
   localparam int StatusW = 2;
   localparam int CountW  = 5;

   // Highest position a request can name, plus one.
   localparam int PosSpan = 1 << PosW;

   // Packed bus widths, rounded up to whole bytes.
   localparam int ReqDataW = ((ValueW + PosW + 7) / 8) * 8;
   localparam int RspDataW = ((ValueW + CountW + 7) / 8) * 8;

   // Request kinds.
   typedef enum logic [KindW-1:0] {
      KIND_FRONT  = 2'd0,
      KIND_BACK   = 2'd1,
      KIND_REMOVE = 2'd2,
      KIND_READ   = 2'd3
   } kind_type;

   // Response status codes.
   typedef enum logic [StatusW-1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   // Command broadcast to every cell of the chain for one accepted request.
   typedef struct packed {
      logic front;   // shift every entry one place toward the back
      logic back;    // load the new value into the cell at the tail
      logic remove;  // cells at or after the position take their right neighbor
   } cmd_type;

endpackage

// File: rtl/indexed_list_store_unit.sv
// Top level of the indexed list store: request decode, count, result register.
// Depends on ilst_pkg and instantiates one ilst_cell per list entry.
`timescale 1ns / 1ps
//
//  Channel   Direction  Ports          Contents (lowest bit up)
//  request   in         req_t*         tuser: kind; tdata: value, position
//  response  out        rsp_t*         tuser: status; tdata: read_value, count
//
//  The whole chain of cells updates at the transfer edge and the result is registered
//  there, so one request per cycle is sustained while the response side is ready.
//  The response appears the cycle after the request transfer.
//  Reset clears only the entry count and the response valid; entries need no clearing.
//  req_tready is low only while a response is held and rsp_tready is low.

module indexed_list_store_unit #(
   parameter int DEPTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ilst_pkg::ReqDataW-1:0]   req_tdata,   // value[31:0], position[35:32]
   input  logic [ilst_pkg::KindW-1:0]      req_tuser,   // kind[1:0]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ilst_pkg::RspDataW-1:0]   rsp_tdata,   // read_value[31:0], count[36:32]
   output logic [ilst_pkg::StatusW-1:0]    rsp_tuser    // status[1:0]
);
   import ilst_pkg::*;

   localparam int CW     = $clog2(DEPTH + 1);
   localparam int WW     = (CW > PosW) ? CW : PosW;
   localparam int RdSpan = (DEPTH < PosSpan) ? DEPTH : PosSpan;

   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         count_in;
   logic                  rsp_valid_ff;
   logic [ValueW-1:0]     rsp_read_ff;
   logic [ValueW-1:0]     rsp_read_in;
   status_type            rsp_status_ff;
   status_type            rsp_status_in;
   logic [CountW-1:0]     rsp_count_ff;
   logic [CW+CountW-1:0]  count_wide;

   logic                  req_accept;
   kind_type              kind;
   logic [ValueW-1:0]     value;
   logic [PosW-1:0]       position;
   logic [WW-1:0]         pos_w;
   logic [WW-1:0]         cnt_w;
   logic                  full;
   logic                  in_range;
   logic                  is_insert;
   cmd_type               cmd;
   logic [ValueW-1:0]     read_mux;

   logic [ValueW-1:0]     entries [DEPTH];

   // Unpack the request.
   assign kind     = kind_type'(req_tuser);
   assign value    = req_tdata[ValueW-1:0];
   assign position = req_tdata[ValueW+PosW-1:ValueW];

   // A new request is taken whenever the result register is free or draining.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   // Range and capacity checks.
   assign pos_w     = WW'(position);
   assign cnt_w     = WW'(count_ff);
   assign full      = (count_ff == CW'(DEPTH));
   assign in_range  = (pos_w < cnt_w);
   assign is_insert = (kind == KIND_FRONT) || (kind == KIND_BACK);

   // Command broadcast to the chain.
   always_comb begin
      cmd.front  = req_accept && (kind == KIND_FRONT) && !full;
      cmd.back   = req_accept && (kind == KIND_BACK) && !full;
      cmd.remove = req_accept && (kind == KIND_REMOVE) && in_range;
   end

   // Chain of cells; cell zero takes the new value from its left side.
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [ValueW-1:0] left_value;
      logic [ValueW-1:0] right_value;

      if (g == 0) begin : g_head
         assign left_value = value;
      end else begin : g_body
         assign left_value = entries[g-1];
      end

      if (g == DEPTH - 1) begin : g_tail
         assign right_value = entries[g];
      end else begin : g_inner
         assign right_value = entries[g+1];
      end

      ilst_cell #(
         .INDEX (g),
         .CW    (CW)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .count       (count_ff),
         .position    (pos_w[CW-1:0]),
         .new_value   (value),
         .left_value  (left_value),
         .right_value (right_value),
         .entry       (entries[g])
      );
   end

   // Read select over the cells a position can reach.
   always_comb begin
      read_mux = '0;
      for (int i = 0; i < RdSpan; i++) begin
         if (position == PosW'(i)) begin
            read_mux = entries[i];
         end
      end
   end

   // Next count and result fields.
   always_comb begin
      count_in      = count_ff;
      rsp_read_in   = '0;
      rsp_status_in = ST_DONE;
      if (is_insert) begin
         if (full) begin
            rsp_status_in = ST_FULL;
         end else begin
            count_in = count_ff + CW'(1);
         end
      end else if (!in_range) begin
         rsp_status_in = ST_RANGE;
      end else if (kind == KIND_READ) begin
         rsp_read_in = read_mux;
      end else begin
         count_in = count_ff - CW'(1);
      end
   end

   assign count_wide = (CW + CountW)'(count_in);

   // Control state: entry count and response valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            count_ff <= count_in;
         end
         if (req_accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Response payload, loaded on each request transfer.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_read_ff   <= rsp_read_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= count_wide[CountW-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = RspDataW'({rsp_count_ff, rsp_read_ff});

   // The count never passes the capacity.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count exceeds capacity");

   // A refused insert leaves the count unchanged.
   a_full_hold : assert property (@(posedge clock) disable iff (reset)
      (req_accept && is_insert && full) |=> (count_ff == $past(count_ff)))
      else $error("count changed on a refused insert");

   // Every request transfer yields a held response in the next cycle.
   a_rsp_follows : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("response missing after request transfer");

   // Any non-done status carries a zero read value.
   a_err_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != ST_DONE)) |-> (rsp_read_ff == '0))
      else $error("nonzero read value with error status");

endmodule

// File: rtl/ilst_cell.sv
// One storage cell of the list chain: holds one entry and moves it with its neighbors.
// Depends on ilst_pkg for the command struct and field widths.
`timescale 1ns / 1ps

module ilst_cell #(
   parameter int INDEX = 0,
   parameter int CW    = 5
) (
   input  logic                          clock,
   input  ilst_pkg::cmd_type             cmd,
   input  logic [CW-1:0]                 count,
   input  logic [CW-1:0]                 position,
   input  logic [ilst_pkg::ValueW-1:0]   new_value,
   input  logic [ilst_pkg::ValueW-1:0]   left_value,
   input  logic [ilst_pkg::ValueW-1:0]   right_value,
   output logic [ilst_pkg::ValueW-1:0]   entry
);
   import ilst_pkg::*;

   logic [ValueW-1:0] entry_ff;
   logic [ValueW-1:0] entry_in;

   // Next entry: the left neighbor on a front insert (cell zero sees the new
   // value there), the new value at the tail on a back insert, and the right
   // neighbor at or after the removed position.
   always_comb begin
      entry_in = entry_ff;
      if (cmd.front) begin
         entry_in = left_value;
      end else if (cmd.back) begin
         if (count == CW'(INDEX)) begin
            entry_in = new_value;
         end
      end else if (cmd.remove) begin
         if (CW'(INDEX) >= position) begin
            entry_in = right_value;
         end
      end
   end

   // Entry storage; contents are meaningless until written.
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// File: tb/sv/indexed_list_store_unit_tb.sv
// Self-checking testbench for indexed_list_store_unit: random and directed list requests.
// Depends on ilst_pkg and the indexed_list_store_unit RTL; a shadow list predicts every response.
`timescale 1ns / 1ps

module indexed_list_store_unit_tb;
   import ilst_pkg::*;

   localparam int ListDepth   = 16;
   localparam int RandomItems = 1020;

   // One expected response, in the widths of the block.
   typedef struct {
      logic signed [ValueW-1:0] read_value;
      status_type               status;
      logic [CountW-1:0]        count;
   } list_result_type;

   // Shadow copy of the list and the queue of responses still owed by the block.
   class list_response_checker;
      logic signed [ValueW-1:0] shadow_entries [ListDepth];
      int unsigned              shadow_count;
      list_result_type          pending_results [$];
      int unsigned              mismatches;
      int unsigned              requests_seen;
      int unsigned              responses_seen;
      int unsigned              full_refusals;
      int unsigned              range_refusals;
      int unsigned              good_reads;

      function new();
         shadow_count   = 0;
         mismatches     = 0;
         requests_seen  = 0;
         responses_seen = 0;
         full_refusals  = 0;
         range_refusals = 0;
         good_reads     = 0;
      endfunction

      task report(string what);
         mismatches++;
         $display("%0t ns: MISMATCH %s", $time, what);
      endtask

      // Apply one accepted request to the shadow list and queue its response.
      function void note_request(kind_type kind, logic signed [ValueW-1:0] value,
                                 logic [PosW-1:0] pos);
         list_result_type res;
         res.read_value = '0;
         res.status     = ST_DONE;
         requests_seen++;
         if (kind == KIND_FRONT || kind == KIND_BACK) begin
            if (shadow_count >= ListDepth) begin
               res.status = ST_FULL;
            end else if (kind == KIND_FRONT) begin
               for (int i = shadow_count; i > 0; i--)
                  shadow_entries[i] = shadow_entries[i-1];
               shadow_entries[0] = value;
               shadow_count++;
            end else begin
               shadow_entries[shadow_count] = value;
               shadow_count++;
            end
         end else if (pos >= shadow_count) begin
            res.status = ST_RANGE;
         end else if (kind == KIND_READ) begin
            res.read_value = shadow_entries[pos];
         end else begin
            // Later entries close up over the removed one.
            for (int i = pos; i + 1 < shadow_count; i++)
               shadow_entries[i] = shadow_entries[i+1];
            shadow_count--;
         end
         res.count = shadow_count[CountW-1:0];
         if (res.status == ST_FULL)  full_refusals++;
         if (res.status == ST_RANGE) range_refusals++;
         if (kind == KIND_READ && res.status == ST_DONE) good_reads++;
         pending_results.push_back(res);
      endfunction

      // Compare one accepted response with the oldest expectation.
      task check_response(logic signed [ValueW-1:0] read_value, logic [StatusW-1:0] status,
                          logic [CountW-1:0] count);
         list_result_type want;
         responses_seen++;
         if (pending_results.size() == 0) begin
            report($sformatf("response with nothing expected (value %h status %0d count %0d)",
                             read_value, status, count));
         end else begin
            want = pending_results.pop_front();
            if (read_value !== want.read_value)
               report($sformatf("read_value %h, expected %h", read_value, want.read_value));
            if (status !== want.status)
               report($sformatf("status %0d, expected %0d", status, want.status));
            if (count !== want.count)
               report($sformatf("count %0d, expected %0d", count, want.count));
         end
      endtask
   endclass

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata;   // value[31:0], position[35:32]
   logic [KindW-1:0]    req_tuser;   // kind[1:0]
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RspDataW-1:0] rsp_tdata;   // read_value[31:0], count[36:32]
   logic [StatusW-1:0]  rsp_tuser;   // status[1:0]

   list_response_checker sb;
   bit                   no_idle;
   bit                   filling;

   indexed_list_store_unit #(.DEPTH(ListDepth)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // 10 ns clock.
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Idle length: mostly none or short, now and then long; none in quiet stretches.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle)
         return 0;
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Present one request from a falling edge and hold it until its transfer.
   task automatic send_request(kind_type kind, logic signed [ValueW-1:0] value,
                               logic [PosW-1:0] pos);
      int                  gap;
      logic [ReqDataW-1:0] data;
      gap  = pick_gap();
      data = '0;
      data[ValueW-1:0]           = value;
      data[ValueW+PosW-1:ValueW] = pos;
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = data;
      req_tuser  = kind;
      do
         @(posedge clock);
      while (!req_tready);
      sb.note_request(kind, value, pos);
      @(negedge clock);
   endtask

   function automatic logic signed [ValueW-1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      case (r % 4)
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return 32'sh0000_0000;
         default: return -32'sd1;
      endcase
   endfunction

   // One random request, biased so the list keeps swinging between empty and full.
   task automatic send_random_request();
      int          r;
      int unsigned fill;
      kind_type    kind;
      logic signed [ValueW-1:0] value;
      logic [PosW-1:0]          pos;
      fill = sb.shadow_count;
      if (fill >= ListDepth)
         filling = 1'b0;
      else if (fill == 0)
         filling = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         // Noise: any kind at any position.
         kind = kind_type'($urandom_range(0, 3));
         pos  = PosW'($urandom_range(0, PosSpan - 1));
      end else begin
         r = $urandom_range(0, 99);
         if (r < (filling ? 60 : 20))
            kind = ($urandom_range(0, 1) != 0) ? KIND_FRONT : KIND_BACK;
         else if (r < (filling ? 85 : 45))
            kind = KIND_READ;
         else
            kind = KIND_REMOVE;
         pos = PosW'((fill > 0) ? $urandom_range(0, fill - 1)
                                : $urandom_range(0, PosSpan - 1));
      end
      value = ($urandom_range(0, 9) == 0) ? pick_value() : $urandom;
      send_request(kind, value, pos);
   endtask

   // Response side: check at the rising edge, change readiness at the falling edge.
   initial begin : response_sink
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tdata[ValueW-1:0], rsp_tuser,
                              rsp_tdata[ValueW+CountW-1:ValueW]);
         @(negedge clock);
         if (stall > 0) begin
            stall--;
            rsp_tready = (stall == 0);
         end else if (!no_idle && $urandom_range(0, 99) < 30) begin
            stall      = pick_gap() + 1;
            rsp_tready = 1'b0;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   // Main sequence.
   initial begin : stimulus
      int wait_cycles;
      sb         = new();
      no_idle    = 1'b0;
      filling    = 1'b1;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = KIND_FRONT;
      rsp_tready = 1'b0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Directed: requests on an empty list, both inserts, reads in and out of range.
      send_request(KIND_READ,   32'sd0, 4'd0);
      send_request(KIND_REMOVE, 32'sd0, 4'd0);
      send_request(KIND_READ,   32'sd0, 4'd15);
      send_request(KIND_FRONT,  32'sh7FFF_FFFF, 4'd9);
      send_request(KIND_BACK,   32'sh8000_0000, 4'd3);
      send_request(KIND_READ,   32'sd0, 4'd0);
      send_request(KIND_READ,   32'sd0, 4'd1);
      send_request(KIND_READ,   32'sd0, 4'd2);
      send_request(KIND_REMOVE, 32'sd0, 4'd5);
      // Fill the list to its depth.
      for (int i = 0; i < ListDepth - 2; i++)
         send_request((i % 2) ? KIND_BACK : KIND_FRONT,
                      (i % 3 == 0) ? -32'sd1 : ((i % 3 == 1) ? 32'sd0 : $urandom), 4'(i));
      // Full list: both inserts refused, last position readable and removable.
      send_request(KIND_FRONT,  32'sd1, 4'd0);
      send_request(KIND_BACK,   32'sd2, 4'd0);
      send_request(KIND_READ,   32'sd0, 4'd15);
      send_request(KIND_REMOVE, 32'sd0, 4'd15);
      send_request(KIND_READ,   32'sd0, 4'd15);
      send_request(KIND_REMOVE, 32'sd0, 4'd0);
      send_request(KIND_REMOVE, 32'sd0, 4'd7);

      // Random part, with stretches that run without idling on either side.
      for (int n = 0; n < RandomItems; n++) begin
         if (n % 150 == 0)
            no_idle = ($urandom_range(0, 2) == 0);
         send_random_request();
      end
      no_idle    = 1'b0;
      req_tvalid = 1'b0;

      // Drain the responses still owed, then wait a little longer for stray ones.
      wait_cycles = 0;
      while (sb.pending_results.size() != 0 && wait_cycles < 5000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (8) @(posedge clock);
      if (sb.pending_results.size() != 0)
         sb.report($sformatf("%0d responses never arrived", sb.pending_results.size()));

      $display("Covered %0d requests and %0d responses: %0d full refusals, %0d range refusals,",
               sb.requests_seen, sb.responses_seen, sb.full_refusals, sb.range_refusals);
      $display("%0d successful reads, %0d mismatches.", sb.good_reads, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("indexed_list_store_unit test passed");
      end else begin
         $display("indexed_list_store_unit test failed");
      end
      $finish;
   end

   // Watchdog far beyond the slowest correct run.
   initial begin : watchdog
      #5_000_000;
      $display("indexed_list_store_unit test failed");
      $finish;
   end

endmodule

// File: files.f
rtl/ilst_pkg.sv
rtl/ilst_cell.sv
rtl/indexed_list_store_unit.sv
tb/sv/indexed_list_store_unit_tb.sv
